@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the price level book RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on every rising edge outside reset.
`define PLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the general form.
`define PLB_ASSERT_IMP(lbl, ante, cons, msg) \
  `PLB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/core/plb_pkg.sv @@
// Package for the price level book: operation codes, queue item type and defaults.
// Used by plb_front, plb_back and price_level_book.
package plb_pkg;

  localparam int unsigned LevelsDef = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               side;
    logic        [30:0] price;
    logic signed [31:0] qty;
  } item_t;

endpackage

@@ rtl/core/plb_front.sv @@
// Front end of the price level book: accepts updates, decodes the function code
// and holds them in a two-entry queue. Depends on plb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic         [1:0]  func_i,
  input  logic                side_i,
  input  logic         [30:0] price_i,
  input  logic signed  [31:0] quantity_i,
  output logic                q_valid_o,
  output plb_pkg::item_t      q_item_o,
  input  logic                q_take_i
);
  import plb_pkg::*;

  logic [1:0] count_q;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  item_t      slot_q [2];
  item_t      item_in;
  op_e        op_in;
  logic       push;
  logic       pop;

  // Decode the function code into an operation.
  always_comb begin
    case (func_i)
      2'd0:    op_in = OP_ADD;
      2'd1:    op_in = OP_REMOVE;
      2'd2:    op_in = OP_CLEAR;
      default: op_in = OP_NOP;
    endcase
    item_in.op    = op_in;
    item_in.side  = side_i;
    item_in.price = price_i;
    item_in.qty   = quantity_i;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_valid_o && q_take_i;

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= item_in;
  end

  `PLB_ASSERT(a_count_bound, count_q != 2'd3, "queue occupancy out of range")
  `PLB_ASSERT_IMP(a_take_valid, q_take_i, q_valid_o, "back end took from an empty queue")
  `PLB_ASSERT(a_push_count, (push && !pop) |=> (count_q == $past(count_q) + 2'd1),
              "transfer into the queue lost")

endmodule

@@ rtl/core/plb_back.sv @@
// Back end of the price level book: applies one update to the level tables and
// scans them for the best bid and ask. Depends on plb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plb_back #(
  parameter int unsigned Levels = plb_pkg::LevelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  plb_pkg::item_t      q_item_i,
  output logic                q_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                has_bid_o,
  output logic         [30:0] best_bid_price_o,
  output logic signed  [31:0] best_bid_qty_o,
  output logic                has_ask_o,
  output logic         [30:0] best_ask_price_o,
  output logic signed  [31:0] best_ask_qty_o,
  output logic signed  [31:0] spread_o,
  output logic                table_full_o
);
  import plb_pkg::*;

  localparam int unsigned IdxW = $clog2(Levels);
  localparam logic [IdxW:0] CntEnd = (IdxW + 1)'(Levels);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_APPLY, S_BEST, S_OUT
  } state_e;

  state_e            state_q;
  item_t             item_q;
  logic [IdxW:0]     cnt_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic [62:0]       bid_rd_q;
  logic [62:0]       ask_rd_q;
  logic [62:0]       bid_mem [Levels];
  logic [62:0]       ask_mem [Levels];
  logic [Levels-1:0] bid_used_q;
  logic [Levels-1:0] ask_used_q;
  logic              found_q;
  logic [IdxW-1:0]   match_q;
  logic [31:0]       mqty_q;
  logic              free_vld_q;
  logic [IdxW-1:0]   free_q;
  logic              hb_q, ha_q, full_q;
  logic [30:0]       bbp_q, bap_q;
  logic [31:0]       bbq_q, baq_q;

  logic              out_valid_q, has_bid_q, has_ask_q, table_full_q;
  logic [30:0]       best_bid_price_q, best_ask_price_q;
  logic [31:0]       best_bid_qty_q, best_ask_qty_q, spread_q;

  logic              we_bid, we_ask;
  logic [IdxW-1:0]   waddr;
  logic [62:0]       wdata;
  logic [31:0]       sum_add, sum_sub;
  logic              sel_used;
  logic [62:0]       sel_rd;

  assign q_take_o = (state_q == S_IDLE) && q_valid_i;
  assign sum_add  = mqty_q + item_q.qty;
  assign sum_sub  = mqty_q - item_q.qty;
  assign sel_used = item_q.side ? bid_used_q[rd_idx_q] : ask_used_q[rd_idx_q];
  assign sel_rd   = item_q.side ? bid_rd_q : ask_rd_q;

  // Table write for the apply step.
  always_comb begin
    we_bid = 1'b0;
    we_ask = 1'b0;
    waddr  = match_q;
    wdata  = {item_q.price, sum_add};
    if (state_q == S_APPLY) begin
      case (item_q.op)
        OP_ADD: begin
          if (found_q) begin
            we_bid = item_q.side;
            we_ask = !item_q.side;
          end else if (free_vld_q) begin
            waddr  = free_q;
            wdata  = {item_q.price, item_q.qty};
            we_bid = item_q.side;
            we_ask = !item_q.side;
          end
        end
        OP_REMOVE: begin
          wdata  = {item_q.price, sum_sub};
          we_bid = found_q && item_q.side;
          we_ask = found_q && !item_q.side;
        end
        default: ;
      endcase
    end
  end

  // Level memories with registered read, one read address per scan step.
  always_ff @(posedge clk_i) begin
    if (we_bid) bid_mem[waddr] <= wdata;
    if (we_ask) ask_mem[waddr] <= wdata;
    bid_rd_q <= bid_mem[cnt_q[IdxW-1:0]];
    ask_rd_q <= ask_mem[cnt_q[IdxW-1:0]];
  end

  // Sequencer: match search, apply, best scan and result hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bid_used_q  <= '0;
      ask_used_q  <= '0;
      rd_vld_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            item_q     <= q_item_i;
            cnt_q      <= '0;
            rd_vld_q   <= 1'b0;
            found_q    <= 1'b0;
            free_vld_q <= 1'b0;
            full_q     <= 1'b0;
            state_q    <= S_FIND;
          end
        end
        S_FIND: begin
          rd_vld_q <= (cnt_q < CntEnd);
          rd_idx_q <= cnt_q[IdxW-1:0];
          if (cnt_q < CntEnd) cnt_q <= cnt_q + 1'b1;
          if (rd_vld_q) begin
            if (sel_used && (sel_rd[62:32] == item_q.price) && !found_q) begin
              found_q <= 1'b1;
              match_q <= rd_idx_q;
              mqty_q  <= sel_rd[31:0];
            end
            if (!sel_used && !free_vld_q) begin
              free_vld_q <= 1'b1;
              free_q     <= rd_idx_q;
            end
          end
          if ((cnt_q == CntEnd) && !rd_vld_q) state_q <= S_APPLY;
        end
        S_APPLY: begin
          case (item_q.op)
            OP_ADD: begin
              if (!found_q && free_vld_q) begin
                if (item_q.side) bid_used_q[free_q] <= 1'b1;
                else ask_used_q[free_q] <= 1'b1;
              end
              full_q <= !found_q && !free_vld_q;
            end
            OP_REMOVE: begin
              if (found_q && (sum_sub == 32'd0)) begin
                if (item_q.side) bid_used_q[match_q] <= 1'b0;
                else ask_used_q[match_q] <= 1'b0;
              end
            end
            OP_CLEAR: begin
              bid_used_q <= '0;
              ask_used_q <= '0;
            end
            default: ;
          endcase
          cnt_q    <= '0;
          rd_vld_q <= 1'b0;
          hb_q     <= 1'b0;
          ha_q     <= 1'b0;
          bbp_q    <= '0;
          bbq_q    <= '0;
          bap_q    <= '0;
          baq_q    <= '0;
          state_q  <= S_BEST;
        end
        S_BEST: begin
          rd_vld_q <= (cnt_q < CntEnd);
          rd_idx_q <= cnt_q[IdxW-1:0];
          if (cnt_q < CntEnd) cnt_q <= cnt_q + 1'b1;
          if (rd_vld_q) begin
            if (bid_used_q[rd_idx_q] && (!hb_q || (bid_rd_q[62:32] > bbp_q))) begin
              hb_q  <= 1'b1;
              bbp_q <= bid_rd_q[62:32];
              bbq_q <= bid_rd_q[31:0];
            end
            if (ask_used_q[rd_idx_q] && (!ha_q || (ask_rd_q[62:32] < bap_q))) begin
              ha_q  <= 1'b1;
              bap_q <= ask_rd_q[62:32];
              baq_q <= ask_rd_q[31:0];
            end
          end
          if ((cnt_q == CntEnd) && !rd_vld_q) begin
            out_valid_q      <= 1'b1;
            has_bid_q        <= hb_q;
            has_ask_q        <= ha_q;
            best_bid_price_q <= bbp_q;
            best_bid_qty_q   <= bbq_q;
            best_ask_price_q <= bap_q;
            best_ask_qty_q   <= baq_q;
            spread_q         <= (hb_q && ha_q) ? ({1'b0, bap_q} - {1'b0, bbp_q}) : 32'd0;
            table_full_q     <= full_q;
            state_q          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign has_bid_o        = has_bid_q;
  assign best_bid_price_o = best_bid_price_q;
  assign best_bid_qty_o   = best_bid_qty_q;
  assign has_ask_o        = has_ask_q;
  assign best_ask_price_o = best_ask_price_q;
  assign best_ask_qty_o   = best_ask_qty_q;
  assign spread_o         = spread_q;
  assign table_full_o     = table_full_q;

  `PLB_ASSERT_IMP(a_out_state, out_valid_q, state_q == S_OUT, "result shown outside hold state")
  `PLB_ASSERT_IMP(a_full_add, out_valid_q && table_full_q, item_q.op == OP_ADD,
                  "table full flagged for an update that is not an add")
  `PLB_ASSERT_IMP(a_no_bid_zero, out_valid_q && !has_bid_q,
                  (best_bid_price_q == 31'd0) && (best_bid_qty_q == 32'd0),
                  "absent bid reported with nonzero fields")

endmodule

@@ rtl/core/price_level_book.sv @@
// Price level book: each update runs a match scan and a best-price scan over
// the level tables through the single read port of each level memory. The
// back end takes a new update only after the result of the last one has left
// the output. Two further updates may queue in the front end.
// Reset clears the level used bits at once; no clearing pass is needed.
// Depends on plb_pkg, plb_front and plb_back.
module price_level_book #(
  parameter int unsigned Levels = plb_pkg::LevelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic         [1:0]  func_i,
  input  logic                side_i,
  input  logic         [30:0] price_i,
  input  logic signed  [31:0] quantity_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                has_bid_o,
  output logic         [30:0] best_bid_price_o,
  output logic signed  [31:0] best_bid_qty_o,
  output logic                has_ask_o,
  output logic         [30:0] best_ask_price_o,
  output logic signed  [31:0] best_ask_qty_o,
  output logic signed  [31:0] spread_o,
  output logic                table_full_o
);
  import plb_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_take;

  // Front end: input transfer and decode queue.
  plb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .side_i     (side_i),
    .price_i    (price_i),
    .quantity_i (quantity_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_take_i   (q_take)
  );

  // Back end: table update and top of book scan.
  plb_back #(
    .Levels (Levels)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_take_o         (q_take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .has_bid_o        (has_bid_o),
    .best_bid_price_o (best_bid_price_o),
    .best_bid_qty_o   (best_bid_qty_o),
    .has_ask_o        (has_ask_o),
    .best_ask_price_o (best_ask_price_o),
    .best_ask_qty_o   (best_ask_qty_o),
    .spread_o         (spread_o),
    .table_full_o     (table_full_o)
  );

endmodule

@@ tb/sv/price_level_book_tb.sv @@
// Testbench for price_level_book: drives random and directed book updates and
// checks every top-of-book report against a behavioural copy of the book.
// Depends on plb_pkg and the price_level_book RTL only.
`timescale 1ns / 100ps

import plb_pkg::*;

// Expected top-of-book report for one update.
typedef struct packed {
  logic               has_bid;
  logic        [30:0] bid_price;
  logic signed [31:0] bid_qty;
  logic               has_ask;
  logic        [30:0] ask_price;
  logic signed [31:0] ask_qty;
  logic signed [31:0] spread;
  logic               full;
} tob_t;

// Book model and queue of expected reports.
class book_board;
  localparam int N = LevelsDef;
  logic        [30:0] lvl_price[2][N];
  logic signed [31:0] lvl_qty[2][N];
  bit                 lvl_used[2][N];
  tob_t               pending[$];
  int                 errors;
  int                 reports;
  int                 drops;

  function new();
    errors = 0;
    reports = 0;
    drops = 0;
    foreach (lvl_used[s, i]) lvl_used[s][i] = 1'b0;
  endfunction

  function int find_level(int s, logic [30:0] p);
    for (int i = 0; i < N; i++)
      if (lvl_used[s][i] && lvl_price[s][i] == p) return i;
    return -1;
  endfunction

  function int used_count(int s);
    int c;
    c = 0;
    for (int i = 0; i < N; i++) c += lvl_used[s][i];
    return c;
  endfunction

  // Apply one accepted update and queue the report it must produce.
  function void note_update(op_e op, logic sd, logic [30:0] p, logic signed [31:0] q);
    tob_t r;
    int   s;
    int   k;
    int   b;
    int   a;
    s = sd;
    r.full = 1'b0;
    case (op)
      OP_ADD: begin
        k = find_level(s, p);
        if (k >= 0) begin
          lvl_qty[s][k] = lvl_qty[s][k] + q;
        end else begin
          for (int i = 0; i < N; i++)
            if (!lvl_used[s][i] && k < 0) k = i;
          if (k < 0) begin
            r.full = 1'b1;
            drops++;
          end else begin
            lvl_used[s][k] = 1'b1;
            lvl_price[s][k] = p;
            lvl_qty[s][k] = q;
          end
        end
      end
      OP_REMOVE: begin
        k = find_level(s, p);
        if (k >= 0) begin
          lvl_qty[s][k] = lvl_qty[s][k] - q;
          if (lvl_qty[s][k] == 32'sd0) lvl_used[s][k] = 1'b0;
        end
      end
      OP_CLEAR: begin
        foreach (lvl_used[x, i]) lvl_used[x][i] = 1'b0;
      end
      default: ;
    endcase
    b = -1;
    a = -1;
    for (int i = 0; i < N; i++) begin
      if (lvl_used[1][i] && (b < 0 || lvl_price[1][i] > lvl_price[1][b])) b = i;
      if (lvl_used[0][i] && (a < 0 || lvl_price[0][i] < lvl_price[0][a])) a = i;
    end
    r.has_bid = b >= 0;
    r.bid_price = b >= 0 ? lvl_price[1][b] : '0;
    r.bid_qty = b >= 0 ? lvl_qty[1][b] : '0;
    r.has_ask = a >= 0;
    r.ask_price = a >= 0 ? lvl_price[0][a] : '0;
    r.ask_qty = a >= 0 ? lvl_qty[0][a] : '0;
    r.spread = (a >= 0 && b >= 0) ? $signed({1'b0, r.ask_price} - {1'b0, r.bid_price}) : '0;
    pending.push_back(r);
  endfunction

  // Compare one report from the block with the oldest expectation.
  function void check_report(tob_t got);
    tob_t exp_r;
    reports++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("report %0d arrived with none expected", reports);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      errors++;
      if (errors <= 10)
        $display("report %0d mismatch: expected %p, got %p", reports, exp_r, got);
    end
  endfunction
endclass

module price_level_book_tb;
  localparam int NRAND = 520;
  localparam int LIMIT = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic        [1:0]  func_i = '0;
  logic               side_i = 1'b0;
  logic        [30:0] price_i = '0;
  logic signed [31:0] quantity_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               has_bid_o;
  logic        [30:0] best_bid_price_o;
  logic signed [31:0] best_bid_qty_o;
  logic               has_ask_o;
  logic        [30:0] best_ask_price_o;
  logic signed [31:0] best_ask_qty_o;
  logic signed [31:0] spread_o;
  logic               table_full_o;

  book_board board = new();
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  hold_off = 1'b0;
  int  sent = 0;

  price_level_book dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Cycle counter with a hard limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      board.check_report('{has_bid_o, best_bid_price_o, best_bid_qty_o, has_ask_o,
                           best_ask_price_o, best_ask_qty_o, spread_o, table_full_o});
    out_stall_i <= hold_off || (!calm && $urandom_range(99) < 9);
  end

  initial begin
    wait (sent == 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Offer one update and wait for its transfer.
  task automatic send(op_e op, logic sd, logic [30:0] p, logic signed [31:0] q);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    side_i <= sd;
    price_i <= p;
    quantity_i <= q;
    do @(posedge clk_i); while (in_stall_o);
    board.note_update(op, sd, p, q);
    sent++;
  endtask

  // Prices mostly from a narrow band so that levels are hit repeatedly.
  function automatic logic [30:0] pick_price(int band);
    case ($urandom_range(9))
      0: return 31'h7fff_ffff - 31'($urandom_range(band));
      1: return 31'($urandom_range(band));
      2: return 31'($urandom);
      default: return 31'd1000 + 31'($urandom_range(band));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_qty();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return -32'sh8000_0000;
      3: return 32'sd0;
      default: return $urandom_range(1, 50);
    endcase
  endfunction

  initial begin
    int band;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every operation, wrap, removal to zero, overflow.
    send(OP_ADD, 1'b1, 31'd0, 32'sd10);
    send(OP_ADD, 1'b0, 31'h7fff_ffff, 32'sd5);
    send(OP_ADD, 1'b1, 31'h7fff_fffe, 32'sh7fff_ffff);
    send(OP_ADD, 1'b1, 31'h7fff_fffe, 32'sd1);
    send(OP_ADD, 1'b0, 31'd7, 32'sd0);
    send(OP_REMOVE, 1'b0, 31'd7, 32'sd0);
    send(OP_REMOVE, 1'b0, 31'd8, 32'sd3);
    send(OP_REMOVE, 1'b1, 31'd0, 32'sd4);
    send(OP_REMOVE, 1'b1, 31'd0, 32'sd6);
    send(OP_REMOVE, 1'b1, 31'h7fff_fffe, -32'sh8000_0000);
    send(OP_NOP, 1'b1, 31'h5555_5555, -32'sd1);
    send(OP_ADD, 1'b0, 31'd0, -32'sd1);
    send(OP_CLEAR, 1'b0, 31'd0, 32'sd0);
    for (int i = 0; i < LevelsDef; i++) send(OP_ADD, 1'b0, 31'(100 + i), 32'sd1);
    send(OP_ADD, 1'b0, 31'd50, 32'sd9);
    send(OP_ADD, 1'b0, 31'd120, 32'sd9);
    send(OP_REMOVE, 1'b0, 31'd100, 32'sd1);
    send(OP_ADD, 1'b0, 31'd50, 32'sd9);
    send(OP_CLEAR, 1'b1, 31'h2aaa_aaaa, 32'sh5555_5555);

    // Random: mostly adds and removes around a band, clears now and then.
    calm = 1'b1;
    for (int n = 0; n < NRAND; n++) begin
      if (n == 100) calm = 1'b0;
      band = (n % 200 < 100) ? 40 : 90;
      case ($urandom_range(99)) inside
        [0:54]:  send(OP_ADD, 1'($urandom), pick_price(band), pick_qty());
        [55:92]: send(OP_REMOVE, 1'($urandom), pick_price(band), pick_qty());
        [93:96]: send(OP_NOP, 1'($urandom), 31'($urandom), $urandom);
        default: send(OP_CLEAR, 1'($urandom), 31'($urandom), $urandom);
      endcase
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * LevelsDef + 20) @(posedge clk_i);
    $display("Sent %0d updates, checked %0d reports, %0d dropped adds seen.",
             sent, board.reports, board.drops);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
